// ===== hdl/ipv4_header_receive_filter_unit_defines.svh =====
// assertion macros for the ipv4 header receive filter rtl
`ifndef IPV4_HEADER_RECEIVE_FILTER_UNIT_DEFINES_SVH
`define IPV4_HEADER_RECEIVE_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IHRF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihrf assertion failed");
// next-cycle implication
`define IHRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihrf assertion failed");
`else
`define IHRF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define IHRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/ihrf_pkg.sv =====
// package: constants, types and codes of the ipv4 header receive filter
package ihrf_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int POS_W = 5;
   localparam int SUM_W = 20;
   localparam int ADDR_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [POS_W-1:0] POS_TOTAL_LENGTH_LOW = 5'd3;
   localparam logic [POS_W-1:0] POS_TTL = 5'd8;
   localparam logic [POS_W-1:0] POS_PROTOCOL = 5'd9;
   localparam logic [POS_W-1:0] POS_CHECKSUM_LOW = 5'd11;
   localparam logic [POS_W-1:0] POS_SOURCE_FIRST = 5'd12;
   localparam logic [POS_W-1:0] POS_SOURCE_LAST = 5'd15;
   localparam logic [POS_W-1:0] POS_DEST_FIRST = 5'd16;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] POS_END = POS_W'(HEADER_BYTES);

   localparam logic [7:0] PROTO_ICMP = 8'h01;
   localparam logic [7:0] PROTO_TCP = 8'h06;
   localparam logic [7:0] PROTO_UDP = 8'h11;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS_PORT0 = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS_PORT1 = 1'b1;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      VERDICT_OWN_SOURCE = 3'd0,
      VERDICT_BAD_CHECKSUM = 3'd1,
      VERDICT_TTL_ZERO = 3'd2,
      VERDICT_ICMP = 3'd3,
      VERDICT_TCP = 3'd4,
      VERDICT_UDP = 3'd5,
      VERDICT_UNKNOWN_PROTOCOL = 3'd6
   } verdict_type;

   // one finished header as handed from parser to verdict stage
   typedef struct packed {
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] destination;
      logic [15:0] stored_checksum;
      logic [SUM_W-1:0] header_sum;
      logic [7:0] ttl;
      logic [7:0] protocol;
      logic [15:0] total_length;
      logic port;
   } hdr_record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ===== hdl/ipv4_header_receive_filter_unit.sv =====
// top level of the ipv4 header receive filter: parser, record queue, verdict stage
// throughput: one header byte per cycle; req_ready drops only while the two-entry
//   record queue is full, which happens only when rsp_ready is held low
// ordering: the record enters the queue at the edge that accepts the last header byte,
//   then enters the verdict register when popped; a pop waits while an untaken verdict is held
// reset: synchronous, active high; clears byte position, queue pointers, output valid
//   and both own-address registers
module ipv4_header_receive_filter_unit import ihrf_pkg::*; (
   input  logic clock,
   input  logic reset,
   // header byte channel
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_header_byte,
   input  logic req_port,
   input  logic req_first_byte,
   // verdict channel
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_verdict,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_destination_address,
   output logic [15:0] rsp_payload_length,
   // configuration writes
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0] csr_write_data
);

   logic byte_accept;
   logic push;
   logic pop;
   hdr_record_type push_record;
   hdr_record_type head_record;
   fifo_status_type status;

   // bytes are taken whenever the queue has room, so the parser never stalls
   // on its own; only the final byte of a header actually pushes a record
   assign req_ready = !status.full;
   assign byte_accept = req_valid && req_ready;

   // front: position counter, one's-complement running sum, field capture
   ihrf_front u_front (
      .clock(clock),
      .reset(reset),
      .byte_accept(byte_accept),
      .header_byte(req_header_byte),
      .port(req_port),
      .first_byte(req_first_byte),
      .push(push),
      .push_record(push_record)
   );

   // decoupling queue so parser and result side stall independently
   ihrf_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_record(push_record),
      .pop(pop),
      .head_record(head_record),
      .status(status)
   );

   // back: fold and compare checksum, prioritized drop checks, protocol sort
   ihrf_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .head_record(head_record),
      .status(status),
      .pop(pop),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_verdict(rsp_verdict),
      .rsp_source_address(rsp_source_address),
      .rsp_destination_address(rsp_destination_address),
      .rsp_payload_length(rsp_payload_length)
   );

endmodule

// ===== hdl/ihrf_front.sv =====
// byte parser: tracks header position, running sum and header fields
module ihrf_front import ihrf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic byte_accept,
   input  logic [7:0] header_byte,
   input  logic port,
   input  logic first_byte,
   output logic push,
   output hdr_record_type push_record
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [7:0] high_ff, high_in;
   logic [15:0] checksum_ff, checksum_in;
   logic [7:0] ttl_ff, ttl_in;
   logic [7:0] proto_ff, proto_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [15:0] total_ff, total_in;
   logic port_ff, port_in;

   logic [POS_W-1:0] pos;
   logic [SUM_W-1:0] sum_base;
   logic [SUM_W-1:0] sum_add;
   logic [15:0] word;

   always_comb begin
      pos = first_byte ? '0 : pos_ff;
      sum_base = (pos == '0) ? '0 : sum_ff;
      word = {high_ff, header_byte};
      sum_add = sum_base + {{(SUM_W-16){1'b0}}, word};

      pos_in = pos_ff;
      sum_in = sum_ff;
      high_in = high_ff;
      checksum_in = checksum_ff;
      ttl_in = ttl_ff;
      proto_in = proto_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      total_in = total_ff;
      port_in = port_ff;

      if (byte_accept && (pos < POS_END)) begin
         pos_in = pos + 1'b1;
         sum_in = sum_base;
         if (pos == '0) begin
            port_in = port;
         end
         if (!pos[0]) begin
            high_in = header_byte;
         end else if (pos == POS_CHECKSUM_LOW) begin
            checksum_in = word;
         end else begin
            sum_in = sum_add;
         end
         if (pos == POS_TOTAL_LENGTH_LOW) begin
            total_in = word;
         end
         if (pos == POS_TTL) begin
            ttl_in = header_byte;
         end else if (pos == POS_PROTOCOL) begin
            proto_in = header_byte;
         end else if (pos >= POS_SOURCE_FIRST && pos <= POS_SOURCE_LAST) begin
            src_in = {src_ff[ADDR_W-9:0], header_byte};
         end else if (pos >= POS_DEST_FIRST) begin
            dst_in = {dst_ff[ADDR_W-9:0], header_byte};
         end
      end

      push = byte_accept && (pos == POS_LAST);
      push_record.source = src_ff;
      push_record.destination = {dst_ff[ADDR_W-9:0], header_byte};
      push_record.stored_checksum = checksum_ff;
      push_record.header_sum = sum_add;
      push_record.ttl = ttl_ff;
      push_record.protocol = proto_ff;
      push_record.total_length = total_ff;
      push_record.port = port_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      sum_ff <= sum_in;
      high_ff <= high_in;
      checksum_ff <= checksum_in;
      ttl_ff <= ttl_in;
      proto_ff <= proto_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      total_ff <= total_in;
      port_ff <= port_in;
   end

endmodule

// ===== hdl/ihrf_fifo.sv =====
// short queue of finished header records between parser and verdict stage
`include "ipv4_header_receive_filter_unit_defines.svh"
module ihrf_fifo import ihrf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  hdr_record_type push_record,
   input  logic pop,
   output hdr_record_type head_record,
   output fifo_status_type status
);

   hdr_record_type entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
      logic [FIFO_PTR_W-1:0] r;
      if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      status.full = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
      status.empty = (count_ff == '0);
      head_record = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_record;
      end
   end

   `IHRF_ASSERT_IMPLIES(a_no_push_full, clock, reset, status.full, !push)
   `IHRF_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, status.empty, !pop)
   `IHRF_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== hdl/ihrf_back.sv =====
// verdict stage: own-address registers, checksum check, protocol sort, output register
module ihrf_back import ihrf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0] csr_write_data,
   input  hdr_record_type head_record,
   input  fifo_status_type status,
   output logic pop,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [2:0] rsp_verdict,
   output logic [ADDR_W-1:0] rsp_source_address,
   output logic [ADDR_W-1:0] rsp_destination_address,
   output logic [15:0] rsp_payload_length
);

   logic [ADDR_W-1:0] own0_ff, own1_ff;
   logic valid_ff, valid_in;
   verdict_type verdict_ff, verdict_in;
   logic [ADDR_W-1:0] src_ff, dst_ff;
   logic [15:0] len_ff, len_in;

   logic [ADDR_W-1:0] own;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] expect_sum;

   always_comb begin
      pop = !status.empty && (!valid_ff || rsp_ready);
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_ready);

      own = head_record.port ? own1_ff : own0_ff;
      fold1 = {1'b0, head_record.header_sum[15:0]}
            + {13'b0, head_record.header_sum[SUM_W-1:16]};
      fold2 = fold1[15:0] + {15'b0, fold1[16]};
      expect_sum = ~fold2;

      if (head_record.source == own) begin
         verdict_in = VERDICT_OWN_SOURCE;
      end else if (head_record.stored_checksum != expect_sum) begin
         verdict_in = VERDICT_BAD_CHECKSUM;
      end else if (head_record.ttl == 8'd0) begin
         verdict_in = VERDICT_TTL_ZERO;
      end else begin
         unique case (head_record.protocol)
            PROTO_ICMP: verdict_in = VERDICT_ICMP;
            PROTO_TCP: verdict_in = VERDICT_TCP;
            PROTO_UDP: verdict_in = VERDICT_UDP;
            default: verdict_in = VERDICT_UNKNOWN_PROTOCOL;
         endcase
      end

      if (head_record.total_length < 16'(HEADER_BYTES)) begin
         len_in = '0;
      end else begin
         len_in = head_record.total_length - 16'(HEADER_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own0_ff <= '0;
         own1_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_OWN_ADDRESS_PORT0: own0_ff <= csr_write_data;
               CSR_OWN_ADDRESS_PORT1: own1_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      if (pop) begin
         verdict_ff <= verdict_in;
         src_ff <= head_record.source;
         dst_ff <= head_record.destination;
         len_ff <= len_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_source_address = src_ff;
   assign rsp_destination_address = dst_ff;
   assign rsp_payload_length = len_ff;

endmodule
